FILE: hdl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial packet deframer package
// Shared types, status codes and byte constants of the deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int LEN_W = 7;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic [7:0] HEAD_RESET  = 8'd204;
    localparam logic [7:0] TAIL_RESET  = 8'd185;
    localparam logic [7:0] LIMIT_RESET = 8'd128;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEAD  = 2'd0;
    localparam logic [1:0] REG_TAIL  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_GOOD     = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_BAD_TAIL = 3'd4,
        ST_BAD_SUM  = 3'd5,
        ST_NO_CR    = 3'd6,
        ST_NO_LF    = 3'd7
    } status_t;

    typedef enum logic [7:0] {
        PH_HUNT = 8'b0000_0001,
        PH_LEN  = 8'b0000_0010,
        PH_ID   = 8'b0000_0100,
        PH_PAY  = 8'b0000_1000,
        PH_TAIL = 8'b0001_0000,
        PH_SUM  = 8'b0010_0000,
        PH_CR   = 8'b0100_0000,
        PH_LF   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] length_limit;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_index;
    } result_t;

endpackage

FILE: hdl/spd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine and checksum; computes the result of one byte and
// updates the frame state when the byte is stepped.
// ----------------------------------------------------------------------------
module spd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              resync,
    input  spd_pkg::cfg_t     cfg,
    output spd_pkg::result_t  result
);

    spd_pkg::phase_t               phase_reg, phase_next, phase_cur;
    logic [7:0]                    sum_reg, sum_next;
    logic [spd_pkg::LEN_W-1:0]     count_reg, count_next;
    logic [spd_pkg::LEN_W-1:0]     length_reg, length_next;
    logic [7:0]                    id_reg, id_next;
    spd_pkg::status_t              status;
    logic [7:0]                    pbyte;
    logic [spd_pkg::LEN_W-1:0]     pidx;
    logic [spd_pkg::LEN_W-1:0]     count_inc;
    logic                          len_ok;

    assign count_inc = count_reg + 1'b1;
    // A length byte must be nonzero, below the limit and fit in seven bits.
    assign len_ok = (rx_byte != 8'd0) && (rx_byte < cfg.length_limit) && !rx_byte[7];

    // Next-state and result logic for one byte.
    always_comb begin
        phase_cur   = resync ? spd_pkg::PH_HUNT : phase_reg;
        phase_next  = phase_cur;
        sum_next    = sum_reg;
        count_next  = count_reg;
        length_next = length_reg;
        id_next     = id_reg;
        status      = spd_pkg::ST_PROGRESS;
        pbyte       = 8'd0;
        pidx        = '0;
        unique case (phase_cur)
            spd_pkg::PH_HUNT: begin
                if (rx_byte == cfg.head_byte) phase_next = spd_pkg::PH_LEN;
            end
            spd_pkg::PH_LEN: begin
                if (len_ok) begin
                    length_next = rx_byte[spd_pkg::LEN_W-1:0];
                    phase_next  = spd_pkg::PH_ID;
                end else begin
                    status     = spd_pkg::ST_BAD_LEN;
                    phase_next = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_ID: begin
                id_next    = rx_byte;
                sum_next   = rx_byte;
                count_next = '0;
                phase_next = (length_reg == spd_pkg::LEN_W'(1)) ? spd_pkg::PH_TAIL
                                                                 : spd_pkg::PH_PAY;
            end
            spd_pkg::PH_PAY: begin
                status     = spd_pkg::ST_PAYLOAD;
                pbyte      = rx_byte;
                pidx       = count_reg;
                // Rotate right by one, then add the byte modulo 256.
                sum_next   = {sum_reg[0], sum_reg[7:1]} + rx_byte;
                count_next = count_inc;
                if (({1'b0, count_inc} + 8'd1) >= {1'b0, length_reg})
                    phase_next = spd_pkg::PH_TAIL;
            end
            spd_pkg::PH_TAIL: begin
                if (rx_byte == cfg.tail_byte) begin
                    phase_next = spd_pkg::PH_SUM;
                end else begin
                    status     = spd_pkg::ST_BAD_TAIL;
                    phase_next = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_SUM: begin
                if (rx_byte == sum_reg) begin
                    phase_next = spd_pkg::PH_CR;
                end else begin
                    status     = spd_pkg::ST_BAD_SUM;
                    phase_next = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_CR: begin
                if (rx_byte == spd_pkg::BYTE_CR) begin
                    phase_next = spd_pkg::PH_LF;
                end else begin
                    status     = spd_pkg::ST_NO_CR;
                    phase_next = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_LF: begin
                phase_next = spd_pkg::PH_HUNT;
                status     = (rx_byte == spd_pkg::BYTE_LF) ? spd_pkg::ST_GOOD
                                                           : spd_pkg::ST_NO_LF;
            end
            default: begin
                phase_next = spd_pkg::PH_HUNT;
                status     = (rx_byte == spd_pkg::BYTE_LF) ? spd_pkg::ST_GOOD
                                                           : spd_pkg::ST_NO_LF;
            end
        endcase
    end

    // Result fields show the held ID and length after this byte.
    always_comb begin
        result.status        = status;
        result.frame_id      = id_next;
        result.frame_length  = length_next;
        result.payload_byte  = pbyte;
        result.payload_index = pidx;
    end

    // Frame state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= spd_pkg::PH_HUNT;
            sum_reg    <= 8'd0;
            count_reg  <= '0;
            length_reg <= '0;
            id_reg     <= 8'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            id_reg     <= id_next;
        end
    end

endmodule

FILE: hdl/serial_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial packet deframer
// Parses head, length, ID, payload, tail, checksum, CR, LF frames from a
// byte stream and reports one status item for every received byte.
// ----------------------------------------------------------------------------
//  Channel | Direction | Moves
//  --------+-----------+---------------------------------------------------
//  s_      | in        | one received byte and the resync flag per item
//  m_      | out       | status, frame ID/length, payload byte and index
//  cfg_    | in        | register writes: head byte, tail byte, length limit
//
//  One item per clock sustained while the result side is not stalled; an
//  accepted item enters the input register and then the result register,
//  from which its result is offered.
//  The frame state advances as an item moves from the input register into
//  the result register, so a stalled result holds the whole pipeline.
//  Reset is synchronous and active low; it empties both registers and
//  returns the parser to the head-byte hunt with the reset register values.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] resync, [15:9] zero
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] frame_id, [14:8] frame_length,
                                   // [22:15] payload_byte, [29:23] payload_index,
                                   // [31:30] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    spd_pkg::cfg_t    cfg_reg;
    spd_pkg::result_t result;
    spd_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_resync_reg;
    logic             out_valid_reg;
    logic             advance;

    // An item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_byte    <= spd_pkg::HEAD_RESET;
            cfg_reg.tail_byte    <= spd_pkg::TAIL_RESET;
            cfg_reg.length_limit <= spd_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                spd_pkg::REG_HEAD:  cfg_reg.head_byte    <= cfg_data;
                spd_pkg::REG_TAIL:  cfg_reg.tail_byte    <= cfg_data;
                spd_pkg::REG_LIMIT: cfg_reg.length_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg   <= s_tdata[7:0];
            in_resync_reg <= s_tdata[8];
        end
    end

    spd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .resync  (in_resync_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.payload_index, out_reg.payload_byte,
                       out_reg.frame_length, out_reg.frame_id};

endmodule

FILE: hdl/spd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the deframer ports and flags results that break its rules.
// ----------------------------------------------------------------------------
module spd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Reset empties the result side.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Payload byte and index are zero unless the item is a payload byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != spd_pkg::ST_PAYLOAD) |-> (m_tdata[29:15] == 15'd0))
        else $error("payload fields set on a non-payload item");

    // A payload byte only occurs inside a frame with an accepted length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == spd_pkg::ST_PAYLOAD) |->
            (m_tdata[14:8] != 7'd0) && (m_tdata[29:23] < m_tdata[14:8]))
        else $error("payload item outside a valid frame length");

endmodule

bind serial_packet_deframer_top spd_checker u_spd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/serial_packet_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial packet deframer testbench
// Feeds byte streams into the deframer: a short table of hand-picked bytes,
// then random frames, both clean and damaged, mixed with line noise. The
// run goes through several register settings and several patterns of idle
// and stall on the two stream ports. A behavioral parser kept in the bench
// predicts the status item of every accepted byte, and each result item is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    // One byte to send, with an optional hand-written status.
    typedef struct {
        logic [7:0]       rx_byte;
        logic             resync;
        logic             known;
        spd_pkg::status_t known_status;
    } rx_item_t;

    // Kinds of damage applied to a random frame.
    typedef enum int {
        FR_CLEAN, FR_BAD_LEN, FR_BAD_TAIL, FR_BAD_SUM, FR_NO_CR, FR_NO_LF, FR_CUT
    } frame_flaw_t;

    // Register setting, traffic pattern and amount of traffic of one session.
    typedef struct {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] length_limit;
        int         sender_idle;
        int         receiver_stall;
        int         n_items;
        bit         squeeze;
    } session_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = spd_pkg::REG_HEAD;
    logic [7:0]  cfg_data  = '0;

    // Parser state and registers as the bench sees them.
    spd_pkg::cfg_t             cfg_model    = '{spd_pkg::HEAD_RESET, spd_pkg::TAIL_RESET,
                                                spd_pkg::LIMIT_RESET};
    spd_pkg::phase_t           parse_phase  = spd_pkg::PH_HUNT;
    logic [7:0]                sum_model    = '0;
    logic [7:0]                id_model     = '0;
    logic [spd_pkg::LEN_W-1:0] count_model  = '0;
    logic [spd_pkg::LEN_W-1:0] length_model = '0;

    rx_item_t          rx_backlog[$];
    rx_item_t          on_wire;
    spd_pkg::result_t  results_due[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int status_seen [8] = '{default: 0};
    int sender_idle    = 0;
    int receiver_stall = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int idle_run       = 0;

    // Hand-picked bytes under the reset register values (head CC, tail B9).
    rx_item_t directed_rows [23] = '{
        '{8'h00, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // hunting, lowest byte
        '{8'hFF, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // hunting, highest byte
        '{8'hCC, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // head
        '{8'h00, 1'b0, 1'b1, spd_pkg::ST_BAD_LEN},   // zero length
        '{8'hCC, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},
        '{8'h80, 1'b0, 1'b1, spd_pkg::ST_BAD_LEN},   // length too wide for 7 bits
        '{8'hCC, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},
        '{8'h01, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // length of one: no payload
        '{8'hFF, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // ID
        '{8'hB9, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // tail right after the ID
        '{8'hFF, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // checksum equals the ID
        '{8'h0D, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},
        '{8'h0A, 1'b0, 1'b1, spd_pkg::ST_GOOD},
        '{8'hCC, 1'b1, 1'b1, spd_pkg::ST_PROGRESS},  // head together with resync
        '{8'h03, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},
        '{8'h00, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},  // ID zero
        '{8'hFF, 1'b0, 1'b0, spd_pkg::ST_PROGRESS},  // payload bytes
        '{8'h80, 1'b0, 1'b0, spd_pkg::ST_PROGRESS},
        '{8'h00, 1'b0, 1'b1, spd_pkg::ST_BAD_TAIL},
        '{8'hCC, 1'b0, 1'b1, spd_pkg::ST_PROGRESS},
        '{8'h7F, 1'b0, 1'b0, spd_pkg::ST_PROGRESS},  // largest length
        '{8'h55, 1'b1, 1'b1, spd_pkg::ST_PROGRESS},  // resync mid-frame, fields stale
        '{8'hFF, 1'b0, 1'b1, spd_pkg::ST_PROGRESS}
    };

    // Register settings, from the reset values to the extremes.
    session_t plan [7] = '{
        '{8'hCC, 8'hB9, 8'd128,  0,  0, 90, 1'b0},
        '{8'h00, 8'hFF, 8'd2,   71,  0, 60, 1'b0},  // only length one fits
        '{8'hFF, 8'h00, 8'd255,  0, 71, 80, 1'b0},  // limit above the 7-bit range
        '{8'h7E, 8'h0D, 8'd0,   14, 14, 40, 1'b0},  // no length is accepted
        '{8'hAA, 8'h55, 8'd16,   0,  0, 80, 1'b1},
        '{8'h0A, 8'hCC, 8'd1,   14, 14, 30, 1'b0},  // no length is accepted
        '{8'h5A, 8'hA5, 8'd3,   14, 14, 60, 1'b0}
    };

    serial_packet_deframer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Checksum step: rotate right by one, then add the byte.
    function automatic logic [7:0] rot_add(input logic [7:0] sum, input logic [7:0] b);
        return {sum[0], sum[7:1]} + b;
    endfunction

    // Advances the bench parser by one byte and returns the status item it gives.
    function automatic spd_pkg::result_t deframe_byte(input logic [7:0] b,
                                                      input logic resync);
        spd_pkg::result_t r;
        r = '0;
        r.status = spd_pkg::ST_PROGRESS;
        if (resync) parse_phase = spd_pkg::PH_HUNT;
        case (parse_phase)
            spd_pkg::PH_HUNT: begin
                if (b == cfg_model.head_byte) parse_phase = spd_pkg::PH_LEN;
            end
            spd_pkg::PH_LEN: begin
                if (b >= 8'd1 && b < cfg_model.length_limit && b <= 8'd127) begin
                    length_model = b[spd_pkg::LEN_W-1:0];
                    parse_phase  = spd_pkg::PH_ID;
                end else begin
                    r.status    = spd_pkg::ST_BAD_LEN;
                    parse_phase = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_ID: begin
                id_model    = b;
                sum_model   = b;
                count_model = '0;
                parse_phase = (length_model == 7'd1) ? spd_pkg::PH_TAIL : spd_pkg::PH_PAY;
            end
            spd_pkg::PH_PAY: begin
                r.status        = spd_pkg::ST_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = count_model;
                sum_model       = rot_add(sum_model, b);
                count_model     = count_model + 7'd1;
                if ({1'b0, count_model} + 8'd1 >= {1'b0, length_model})
                    parse_phase = spd_pkg::PH_TAIL;
            end
            spd_pkg::PH_TAIL: begin
                if (b == cfg_model.tail_byte) begin
                    parse_phase = spd_pkg::PH_SUM;
                end else begin
                    r.status    = spd_pkg::ST_BAD_TAIL;
                    parse_phase = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_SUM: begin
                if (b == sum_model) begin
                    parse_phase = spd_pkg::PH_CR;
                end else begin
                    r.status    = spd_pkg::ST_BAD_SUM;
                    parse_phase = spd_pkg::PH_HUNT;
                end
            end
            spd_pkg::PH_CR: begin
                if (b == spd_pkg::BYTE_CR) begin
                    parse_phase = spd_pkg::PH_LF;
                end else begin
                    r.status    = spd_pkg::ST_NO_CR;
                    parse_phase = spd_pkg::PH_HUNT;
                end
            end
            default: begin
                parse_phase = spd_pkg::PH_HUNT;
                r.status    = (b == spd_pkg::BYTE_LF) ? spd_pkg::ST_GOOD : spd_pkg::ST_NO_LF;
            end
        endcase
        r.frame_id     = id_model;
        r.frame_length = length_model;
        return r;
    endfunction

    function automatic void push_rx(input logic [7:0] b, input logic resync);
        rx_item_t it;
        it.rx_byte      = b;
        it.resync       = resync;
        it.known        = 1'b0;
        it.known_status = spd_pkg::ST_PROGRESS;
        rx_backlog.push_back(it);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Sender: offers queued bytes with random gaps and predicts each accepted one.
    always @(posedge aclk) begin : sender
        spd_pkg::result_t predicted;
        logic             offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                predicted = deframe_byte(on_wire.rx_byte, on_wire.resync);
                if (on_wire.known) predicted.status = on_wire.known_status;
                results_due.push_back(predicted);
                bytes_sent++;
                offer = 1'b0;
            end
            if (!offer && rx_backlog.size() != 0 && $urandom_range(99) >= sender_idle) begin
                on_wire = rx_backlog.pop_front();
                offer   = 1'b1;
            end
            s_tvalid <= offer;
            s_tdata  <= {7'd0, on_wire.resync, on_wire.rx_byte};
        end
    end

    // Receiver: checks every accepted result item, stalls at random, and holds
    // off for a long stretch when asked.
    always @(posedge aclk) begin : receiver
        spd_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                status_seen[m_tuser]++;
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got status %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("frame_id", want.frame_id, m_tdata[7:0]);
                    check_field("frame_length", want.frame_length, m_tdata[14:8]);
                    check_field("payload_byte", want.payload_byte, m_tdata[22:15]);
                    check_field("payload_index", want.payload_index, m_tdata[29:23]);
                end
            end
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall);
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
        else idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            spd_pkg::REG_HEAD:  cfg_model.head_byte    = value;
            spd_pkg::REG_TAIL:  cfg_model.tail_byte    = value;
            spd_pkg::REG_LIMIT: cfg_model.length_limit = value;
            default:   ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every byte is sent and every result has come back.
    task automatic wait_idle();
        while (rx_backlog.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Queues random frames, about half well formed and the rest damaged, with noise between.
    task automatic queue_traffic(input int n_items);
        logic [7:0]  body[$];
        logic [7:0]  run_sum, frame_id, len_byte, max_len, pay;
        frame_flaw_t flaw;
        int          queued, n_pay, cut_at;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(4) == 0) begin
                // Line noise, now and then a stray head byte or resync.
                repeat ($urandom_range(4, 1)) begin
                    pay = ($urandom_range(5) == 0) ? cfg_model.head_byte
                                                   : 8'($urandom_range(255));
                    push_rx(pay, $urandom_range(7) == 0);
                end
            end else begin
                flaw = ($urandom_range(1) == 0) ? FR_CLEAN
                                                : frame_flaw_t'($urandom_range(FR_CUT, FR_BAD_LEN));
                if (cfg_model.length_limit < 2) begin
                    len_byte = ($urandom_range(1) == 0) ? 8'($urandom_range(3))
                                                        : 8'($urandom_range(255));
                end else begin
                    max_len = (cfg_model.length_limit > 128) ? 8'd127
                                                             : cfg_model.length_limit - 8'd1;
                    if ($urandom_range(19) == 0) len_byte = max_len;
                    else len_byte = 8'($urandom_range((max_len < 6) ? max_len : 6, 1));
                end
                if (flaw == FR_BAD_LEN)
                    len_byte = ($urandom_range(1) == 0) ? 8'd0
                             : 8'($urandom_range(255, cfg_model.length_limit));
                if (flaw == FR_BAD_LEN || cfg_model.length_limit < 2)
                    n_pay = int'($urandom_range(2));
                else n_pay = len_byte - 1;

                frame_id = 8'($urandom_range(255));
                run_sum  = frame_id;
                body.delete();
                body.push_back(cfg_model.head_byte);
                body.push_back(len_byte);
                body.push_back(frame_id);
                for (int i = 0; i < n_pay; i++) begin
                    pay     = 8'($urandom_range(255));
                    run_sum = rot_add(run_sum, pay);
                    body.push_back(pay);
                end
                body.push_back((flaw == FR_BAD_TAIL)
                               ? cfg_model.tail_byte ^ 8'($urandom_range(255, 1))
                               : cfg_model.tail_byte);
                body.push_back((flaw == FR_BAD_SUM) ? run_sum ^ 8'($urandom_range(255, 1))
                                                    : run_sum);
                body.push_back((flaw == FR_NO_CR)
                               ? spd_pkg::BYTE_CR ^ 8'($urandom_range(255, 1))
                               : spd_pkg::BYTE_CR);
                body.push_back((flaw == FR_NO_LF)
                               ? spd_pkg::BYTE_LF ^ 8'($urandom_range(255, 1))
                               : spd_pkg::BYTE_LF);

                // A cut frame gets a resync somewhere inside, half the time on a new head.
                cut_at = -1;
                if (flaw == FR_CUT) begin
                    cut_at = int'($urandom_range(body.size() - 1, 1));
                    if ($urandom_range(1) == 0) body[cut_at] = cfg_model.head_byte;
                end
                foreach (body[i]) push_rx(body[i], i == cut_at);
                queued += body.size();
            end
        end
    endtask

    initial begin : main
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) rx_backlog.push_back(directed_rows[i]);
        wait_idle();

        foreach (plan[p]) begin
            write_reg(spd_pkg::REG_HEAD, plan[p].head_byte);
            write_reg(spd_pkg::REG_TAIL, plan[p].tail_byte);
            write_reg(spd_pkg::REG_LIMIT, plan[p].length_limit);
            sender_idle    = plan[p].sender_idle;
            receiver_stall = plan[p].receiver_stall;
            queue_traffic(plan[p].n_items);
            if (plan[p].squeeze) hold_asked++;
            wait_idle();
        end

        $display("Sent %0d bytes under %0d register settings, %0d status items checked.",
                 bytes_sent, $size(plan), results_seen);
        $display("Statuses: progress %0d, payload %0d, good %0d, length %0d, tail %0d,",
                 status_seen[spd_pkg::ST_PROGRESS], status_seen[spd_pkg::ST_PAYLOAD],
                 status_seen[spd_pkg::ST_GOOD], status_seen[spd_pkg::ST_BAD_LEN],
                 status_seen[spd_pkg::ST_BAD_TAIL]);
        $display("  checksum %0d, missing CR %0d, missing LF %0d.",
                 status_seen[spd_pkg::ST_BAD_SUM], status_seen[spd_pkg::ST_NO_CR],
                 status_seen[spd_pkg::ST_NO_LF]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
